FILE: rtl/core/rcce_pkg.sv
// Shared types, command codes and frame layout functions for the radar
// control command encoder. No dependencies.
package rcce_pkg;

  // Command kinds carried on the input tuser
  localparam logic [3:0] MODE_POWER    = 4'd0;
  localparam logic [3:0] MODE_SCAN     = 4'd1;
  localparam logic [3:0] MODE_HEIGHT   = 4'd2;
  localparam logic [3:0] MODE_BEARING  = 4'd3;
  localparam logic [3:0] MODE_RANGE    = 4'd4;
  localparam logic [3:0] MODE_GAIN     = 4'd5;
  localparam logic [3:0] MODE_SEA      = 4'd6;
  localparam logic [3:0] MODE_RAIN     = 4'd7;
  localparam logic [3:0] MODE_NOISE    = 4'd8;
  localparam logic [3:0] MODE_SIDELOBE = 4'd9;
  localparam logic [3:0] MODE_INTERF   = 4'd10;
  localparam logic [3:0] MODE_LOCAL    = 4'd11;
  localparam logic [3:0] MODE_EXPAND   = 4'd12;
  localparam logic [3:0] MODE_BOOST    = 4'd13;
  localparam logic [3:0] MODE_SEPARATE = 4'd14;

  localparam logic [7:0] CMD_TAG = 8'hC1;

  // Opcodes (first byte of a frame)
  localparam logic [7:0] OP_POWER_PREP = 8'h00;
  localparam logic [7:0] OP_POWER_SET  = 8'h01;
  localparam logic [7:0] OP_SCAN       = 8'h0F;
  localparam logic [7:0] OP_HEIGHT     = 8'h30;
  localparam logic [7:0] OP_BEARING    = 8'h05;
  localparam logic [7:0] OP_RANGE      = 8'h03;
  localparam logic [7:0] OP_LEVEL      = 8'h06;
  localparam logic [7:0] OP_NOISE      = 8'h21;
  localparam logic [7:0] OP_INTERF     = 8'h08;
  localparam logic [7:0] OP_LOCAL      = 8'h0E;
  localparam logic [7:0] OP_EXPAND     = 8'h09;
  localparam logic [7:0] OP_BOOST      = 8'h0A;
  localparam logic [7:0] OP_SEPARATE   = 8'h22;

  // Level frame selectors and auto defaults
  localparam logic [7:0] SEL_GAIN     = 8'h00;
  localparam logic [7:0] SEL_SEA      = 8'h02;
  localparam logic [7:0] SEL_RAIN     = 8'h04;
  localparam logic [7:0] SEL_SIDELOBE = 8'h05;
  localparam logic [7:0] AUTO_GAIN     = 8'hAD;
  localparam logic [7:0] AUTO_CLUTTER  = 8'hD3;
  localparam logic [7:0] AUTO_SIDELOBE = 8'hC0;

  localparam logic [7:0] LEVEL_MAX   = 8'd255;
  localparam logic [30:0] LEVEL_SAT  = 31'd99;   // (99+1)*255/100 already hits 255

  // Arithmetic constants for the bearing and level paths
  localparam logic [32:0] WRAP_ADJ   = 33'd104;  // (-2^32) mod 360
  localparam logic [13:0] RECIP_360  = 14'd11650; // floor(2^22 / 360)
  localparam logic [12:0] RECIP_100  = 13'd5243;  // ceil(2^19 / 100)
  localparam logic [9:0]  DEG_FULL   = 10'd360;
  localparam logic [15:0] MM_PER_M   = 16'd1000;
  localparam logic [23:0] DM_PER_M   = 24'd10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified request: kind plus up to three argument bytes
  typedef struct packed {
    logic [3:0]  mode;
    logic [23:0] arg;
  } cmd_t;

  function automatic logic [3:0] frame_len(input logic [3:0] mode);
    logic [3:0] len;
    case (mode)
      MODE_POWER:    len = 4'd6;
      MODE_HEIGHT:   len = 4'd10;
      MODE_BEARING:  len = 4'd4;
      MODE_RANGE:    len = 4'd5;
      MODE_GAIN,
      MODE_SEA,
      MODE_RAIN,
      MODE_SIDELOBE: len = 4'd11;
      default:       len = 4'd3;
    endcase
    return len;
  endfunction

  function automatic logic frame_end(input logic [3:0] mode, input logic [3:0] idx);
    logic e;
    if (mode == MODE_POWER) e = (idx == 4'd2) || (idx == 4'd5);
    else                    e = (idx == frame_len(mode) - 4'd1);
    return e;
  endfunction

  function automatic logic [7:0] short_op(input logic [3:0] mode);
    logic [7:0] op;
    case (mode)
      MODE_SCAN:   op = OP_SCAN;
      MODE_NOISE:  op = OP_NOISE;
      MODE_INTERF: op = OP_INTERF;
      MODE_LOCAL:  op = OP_LOCAL;
      MODE_EXPAND: op = OP_EXPAND;
      MODE_BOOST:  op = OP_BOOST;
      default:     op = OP_SEPARATE;
    endcase
    return op;
  endfunction

  function automatic logic [7:0] level_sel(input logic [3:0] mode);
    logic [7:0] s;
    case (mode)
      MODE_GAIN: s = SEL_GAIN;
      MODE_SEA:  s = SEL_SEA;
      MODE_RAIN: s = SEL_RAIN;
      default:   s = SEL_SIDELOBE;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] auto_level(input logic [3:0] mode);
    logic [7:0] d;
    case (mode)
      MODE_GAIN:     d = AUTO_GAIN;
      MODE_SIDELOBE: d = AUTO_SIDELOBE;
      default:       d = AUTO_CLUTTER;
    endcase
    return d;
  endfunction

  // Byte idx of the frame(s) for one classified request
  function automatic logic [7:0] frame_byte(input cmd_t cmd, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (cmd.mode)
      MODE_POWER: begin
        case (idx)
          4'd0:    b = OP_POWER_PREP;
          4'd1:    b = CMD_TAG;
          4'd2:    b = 8'h01;
          4'd3:    b = OP_POWER_SET;
          4'd4:    b = CMD_TAG;
          default: b = cmd.arg[7:0];
        endcase
      end
      MODE_HEIGHT: begin
        case (idx)
          4'd0:    b = OP_HEIGHT;
          4'd1:    b = CMD_TAG;
          4'd2:    b = 8'h01;
          4'd6:    b = cmd.arg[7:0];
          4'd7:    b = cmd.arg[15:8];
          default: b = 8'h00;
        endcase
      end
      MODE_BEARING: begin
        case (idx)
          4'd0:    b = OP_BEARING;
          4'd1:    b = CMD_TAG;
          4'd2:    b = cmd.arg[7:0];
          default: b = cmd.arg[15:8];
        endcase
      end
      MODE_RANGE: begin
        case (idx)
          4'd0:    b = OP_RANGE;
          4'd1:    b = CMD_TAG;
          4'd2:    b = cmd.arg[7:0];
          4'd3:    b = cmd.arg[15:8];
          default: b = cmd.arg[23:16];
        endcase
      end
      MODE_GAIN, MODE_SEA, MODE_RAIN, MODE_SIDELOBE: begin
        case (idx)
          4'd0:    b = OP_LEVEL;
          4'd1:    b = CMD_TAG;
          4'd2:    b = level_sel(cmd.mode);
          4'd6:    b = {7'd0, cmd.arg[8]};
          4'd10:   b = cmd.arg[7:0];
          default: b = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          4'd0:    b = short_op(cmd.mode);
          4'd1:    b = CMD_TAG;
          default: b = cmd.arg[7:0];
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/rcce_front.sv
// Front end: accepts requests, drops unknown kinds and works out the
// argument bytes in a three-stage pipeline. Depends on rcce_pkg.
module rcce_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          mode,
  input  logic [31:0]         value,
  output logic                push,
  output rcce_pkg::cmd_t      cmd,
  input  logic                full
);
  import rcce_pkg::*;

  logic adv;

  // stage 1: wrap offset, 2^16 fold, level product
  logic        s1_valid;
  logic [3:0]  s1_mode;
  logic [31:0] s1_raw;
  logic [21:0] s1_y;
  logic [14:0] s1_p;
  logic        s1_sat;

  // stage 2: reciprocal multiplies and unit products
  logic        s2_valid;
  logic [3:0]  s2_mode;
  logic [31:0] s2_raw;
  logic [21:0] s2_y;
  logic [13:0] s2_q;
  logic [7:0]  s2_lvl;
  logic        s2_sat;
  logic [15:0] s2_mm;
  logic [23:0] s2_dm;

  // stage 3: finished entry
  logic        s3_valid;
  cmd_t        s3_cmd;

  logic [32:0] x;
  logic [21:0] y;
  logic [6:0]  n1;
  logic [35:0] q_prod;
  logic [27:0] l_prod;
  logic [25:0] mm_prod;
  logic [27:0] dm_prod;
  logic [22:0] q360;
  logic [21:0] r_full;
  logic [9:0]  r;
  logic [8:0]  deg;
  logic [11:0] tenth;
  logic        s2_neg;
  logic [23:0] arg_next;

  assign adv      = !(s3_valid && full);
  assign in_ready = adv;
  assign push     = s3_valid && !full;
  assign cmd      = s3_cmd;

  // Negative values: add (-2^32 mod 360), then fold the high half (2^16 = 16 mod 360)
  assign x  = {1'b0, value} + (value[31] ? WRAP_ADJ : 33'd0);
  assign y  = {1'b0, x[32:16], 4'd0} + {6'd0, x[15:0]};
  assign n1 = value[6:0] + 7'd1;

  assign q_prod  = s1_y * RECIP_360;
  assign l_prod  = s1_p * RECIP_100;
  assign mm_prod = s1_raw[15:0] * MM_PER_M[9:0];
  assign dm_prod = s1_raw[23:0] * DM_PER_M[3:0];

  // q * 360 = q * (256 + 64 + 32 + 8)
  assign s2_neg = s2_raw[31];
  assign q360   = {1'b0, s2_q, 8'd0} + {3'd0, s2_q, 6'd0} + {4'd0, s2_q, 5'd0}
                + {6'd0, s2_q, 3'd0};
  assign r_full = s2_y - q360[21:0];
  assign r      = r_full[9:0];
  assign deg    = (r >= DEG_FULL) ? 9'(r - DEG_FULL) : r[8:0];
  assign tenth  = {deg, 3'd0} + {2'd0, deg, 1'b0};

  always_comb begin
    arg_next = {16'd0, s2_raw[7:0]};
    case (s2_mode)
      MODE_POWER:   arg_next = {23'd0, (s2_raw != 32'd0)};
      MODE_HEIGHT:  arg_next = {8'd0, s2_mm};
      MODE_BEARING: arg_next = {12'd0, tenth};
      MODE_RANGE:   arg_next = s2_dm;
      MODE_GAIN, MODE_SEA, MODE_RAIN, MODE_SIDELOBE: begin
        if (s2_neg)      arg_next = {15'd0, 1'b1, auto_level(s2_mode)};
        else if (s2_sat) arg_next = {15'd0, 1'b0, LEVEL_MAX};
        else             arg_next = {15'd0, 1'b0, s2_lvl};
      end
      MODE_LOCAL: begin
        if (s2_neg)                     arg_next = 24'd0;
        else if (s2_raw[30:2] != 29'd0) arg_next = 24'd3;
        else                            arg_next = {22'd0, s2_raw[1:0]};
      end
      default: arg_next = {16'd0, s2_raw[7:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid && (mode <= MODE_SEPARATE);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode <= mode;
      s1_raw  <= value;
      s1_y    <= y;
      s1_p    <= {n1, 8'd0} - {8'd0, n1};
      s1_sat  <= !value[31] && (value[30:0] >= LEVEL_SAT);

      s2_mode <= s1_mode;
      s2_raw  <= s1_raw;
      s2_y    <= s1_y;
      s2_q    <= q_prod[35:22];
      s2_lvl  <= l_prod[26:19];
      s2_sat  <= s1_sat;
      s2_mm   <= mm_prod[15:0];
      s2_dm   <= dm_prod[23:0];

      s3_cmd.mode <= s2_mode;
      s3_cmd.arg  <= arg_next;
    end
  end

endmodule

FILE: rtl/core/rcce_queue.sv
// Short command queue between the front and back ends.
// Depends on rcce_pkg for the entry type and depth.
module rcce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcce_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output rcce_pkg::cmd_t head
);
  import rcce_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

endmodule

FILE: rtl/core/rcce_back.sv
// Back end: walks the head command byte by byte into a registered
// output stage. Depends on rcce_pkg for the frame layout functions.
module rcce_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           nonempty,
  input  rcce_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_end,
  output logic           out_last
);
  import rcce_pkg::*;

  logic [3:0] idx;
  logic       load;
  logic       take;
  logic       at_last;

  assign load    = !out_valid || out_ready;
  assign take    = load && nonempty;
  assign at_last = (idx == frame_len(head.mode) - 4'd1);
  assign pop     = take && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= nonempty;
      if (take) idx <= at_last ? 4'd0 : idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= frame_byte(head, idx);
      out_end  <= frame_end(head.mode, idx);
      out_last <= at_last;
    end
  end

  // last byte of a request always closes a frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_end)
    else $error("request end without frame end");

  // byte counter stays inside the head command's frame
  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    nonempty |-> idx < frame_len(head.mode))
    else $error("byte index past frame length");

  // counter is back at zero after a command is retired
  a_idx_wraps: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == 4'd0)
    else $error("byte index not cleared after pop");

  // output stage is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

FILE: rtl/core/radar_control_command_encoder.sv
// Top level of the radar control command encoder: front end, command
// queue and byte serializer. Depends on rcce_pkg, rcce_front, rcce_queue, rcce_back.
//
// Usage:
//   Input channel (s_axis_*): one item is a control request, a command kind
//   on tuser and a signed 32-bit setting on tdata. Output channel (m_axis_*):
//   one item per frame byte; tuser[0] marks the last byte of a frame, tlast
//   the last byte caused by the request. Kind 15 produces no bytes.
//   Path: the first byte of a request, once accepted, is registered in front
//   stages 2 and 3, the queue and the output register before it is valid on m_axis.
//   Throughput: the output runs one byte per cycle while m_axis_tready is high;
//   a request is 3 to 11 bytes long (power 6, height 10, bearing 4, range 5,
//   gain/sea/rain/side-lobe 11, others 3). The serializer is what sets it.
//   Input takes one item per cycle until the last front stage holds an entry
//   and the four-entry queue is full; s_axis_tready then drops until the back
//   end retires a command.
//   Reset (rst, synchronous) empties the pipeline, queue and output register.
//   When m_axis_tready is low the current byte holds and the back end waits;
//   the front keeps filling the queue meanwhile.
module radar_control_command_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [3:0]  s_axis_tuser,   // [3:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
  output logic [0:0]  m_axis_tuser,   // [0] frame_end
  output logic        m_axis_tlast    // last byte of the request
);
  import rcce_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic nonempty;
  cmd_t front_cmd;
  cmd_t head;
  logic out_end;

  // classify and precompute argument bytes
  rcce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .mode     (s_axis_tuser),
    .value    (s_axis_tdata),
    .push     (push),
    .cmd      (front_cmd),
    .full     (full)
  );

  // decouples request intake from byte output
  rcce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (front_cmd),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  // one byte per cycle into the output register while m_axis_tready allows
  rcce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_end   (out_end),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tuser = out_end;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for radar_control_command_encoder: directed and random
// control requests against a local byte-frame predictor. Depends on rcce_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import rcce_pkg::*;

  localparam int RANDOM_ITEMS = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 20;

  // One expected output byte
  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } cmd_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic [3:0]  s_axis_tuser = '0;   // [3:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] data_byte
  logic [0:0]  m_axis_tuser;        // [0] frame_end
  logic        m_axis_tlast;

  cmd_byte_t pending_bytes[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;           // no idling on either side
  bit        hold_request = 1'b0;   // receiver holds off for HOLD_CYCLES

  radar_control_command_encoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("radar_control_command_encoder test failed");
      $finish;
    end
  end

  // Expected byte stream for one request, appended to pending_bytes
  function automatic void encode_request(input logic [3:0] mode, input logic [31:0] value);
    logic [7:0]  b [0:10];
    logic [10:0] ends;
    logic [31:0] prod;
    logic [15:0] tenths;
    longint      sv;
    longint      d;
    longint      lvl;
    int          n;
    cmd_byte_t   e;
    for (int i = 0; i < 11; i++) b[i] = 8'h00;
    ends = '0;
    n = 0;
    sv = longint'($signed(value));
    case (mode)
      MODE_POWER: begin
        b[0] = OP_POWER_PREP; b[1] = CMD_TAG; b[2] = 8'h01;
        b[3] = OP_POWER_SET;  b[4] = CMD_TAG; b[5] = (value == 32'd0) ? 8'h00 : 8'h01;
        ends[2] = 1'b1;
        n = 6;
      end
      MODE_HEIGHT: begin
        prod = value * 32'd1000;    // millimetres, wraps mod 2^32
        b[0] = OP_HEIGHT; b[1] = CMD_TAG; b[2] = 8'h01;
        b[6] = prod[7:0]; b[7] = prod[15:8];
        n = 10;
      end
      MODE_BEARING: begin
        d = sv % 360;               // truncating, so fold negatives back up
        if (d < 0) d += 360;
        tenths = 16'(d * 10);
        b[0] = OP_BEARING; b[1] = CMD_TAG; b[2] = tenths[7:0]; b[3] = tenths[15:8];
        n = 4;
      end
      MODE_RANGE: begin
        prod = value * 32'd10;      // decimetres
        b[0] = OP_RANGE; b[1] = CMD_TAG;
        b[2] = prod[7:0]; b[3] = prod[15:8]; b[4] = prod[23:16];
        n = 5;
      end
      MODE_GAIN, MODE_SEA, MODE_RAIN, MODE_SIDELOBE: begin
        b[0] = OP_LEVEL;
        b[1] = CMD_TAG;
        case (mode)
          MODE_GAIN: b[2] = SEL_GAIN;
          MODE_SEA:  b[2] = SEL_SEA;
          MODE_RAIN: b[2] = SEL_RAIN;
          default:   b[2] = SEL_SIDELOBE;
        endcase
        if (sv < 0) begin
          b[6] = 8'h01;
          case (mode)
            MODE_GAIN:     b[10] = AUTO_GAIN;
            MODE_SIDELOBE: b[10] = AUTO_SIDELOBE;
            default:       b[10] = AUTO_CLUTTER;
          endcase
        end else begin
          lvl = (sv + 1) * 255 / 100;
          if (lvl > 255) lvl = 255;
          b[10] = 8'(lvl);
        end
        n = 11;
      end
      MODE_SCAN, MODE_NOISE, MODE_INTERF, MODE_LOCAL,
      MODE_EXPAND, MODE_BOOST, MODE_SEPARATE: begin
        case (mode)
          MODE_SCAN:   b[0] = OP_SCAN;
          MODE_NOISE:  b[0] = OP_NOISE;
          MODE_INTERF: b[0] = OP_INTERF;
          MODE_LOCAL:  b[0] = OP_LOCAL;
          MODE_EXPAND: b[0] = OP_EXPAND;
          MODE_BOOST:  b[0] = OP_BOOST;
          default:     b[0] = OP_SEPARATE;
        endcase
        b[1] = CMD_TAG;
        b[2] = value[7:0];
        if (mode == MODE_LOCAL) b[2] = (sv < 0) ? 8'd0 : (sv > 3) ? 8'd3 : value[7:0];
        n = 3;
      end
      default: n = 0;               // unknown kind: no bytes at all
    endcase
    if (n > 0) ends[n-1] = 1'b1;
    for (int i = 0; i < n; i++) begin
      e.data      = b[i];
      e.frame_end = ends[i];
      e.last      = (i == n - 1);
      pending_bytes.push_back(e);
    end
  endfunction

  // Offer one request; returns once it has been taken
  task automatic offer_request(input logic [3:0] mode, input logic [31:0] value);
    if (!calm) begin
      while ($urandom_range(0, 99) < 36) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    encode_request(mode, value);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Half values near the interesting boundaries, half fully random
  function automatic logic [31:0] random_setting();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return $urandom_range(0, 120);
    if (pick < 30) return $urandom_range(0, 1100);
    if (pick < 40) return -$urandom_range(1, 800);
    if (pick < 50) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // Receiver: random backpressure, or a long counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_request = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // Output checker: every accepted byte against the oldest expectation
  always @(posedge clk) begin
    cmd_byte_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h frame_end %b last %b", $time,
                 m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        mismatch_count++;
      end else begin
        e = pending_bytes.pop_front();
        if (m_axis_tdata !== e.data) begin
          $display("%0t: data_byte expected %02h actual %02h", $time, e.data, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== e.frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time, e.frame_end,
                   m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Every kind once or more, with field extremes and the corner cases
  task automatic test_directed();
    offer_request(MODE_POWER, 32'd0);
    offer_request(MODE_POWER, 32'h8000_0000);
    offer_request(MODE_SCAN, 32'hFFFF_FFFF);
    offer_request(MODE_NOISE, 32'd0);
    offer_request(MODE_INTERF, 32'h1234_5680);
    offer_request(MODE_EXPAND, 32'h0000_007F);
    offer_request(MODE_BOOST, 32'h0000_0100);
    offer_request(MODE_SEPARATE, 32'h8000_0000);
    offer_request(MODE_LOCAL, 32'hFFFF_FFFF);          // clamps up to 0
    offer_request(MODE_LOCAL, 32'd2);
    offer_request(MODE_LOCAL, 32'h7FFF_FFFF);          // clamps down to 3
    offer_request(MODE_HEIGHT, 32'h7FFF_FFFF);         // product wraps
    offer_request(MODE_HEIGHT, 32'd66);                // past 16 bits of mm
    offer_request(MODE_BEARING, 32'hFFFF_FFFF);        // negative wraps to 359
    offer_request(MODE_BEARING, 32'h8000_0000);
    offer_request(MODE_BEARING, 32'd359);
    offer_request(MODE_RANGE, 32'hFFFF_FFFF);
    offer_request(MODE_GAIN, 32'hFFFF_FFFF);           // auto
    offer_request(MODE_SEA, 32'd99);                   // first saturating level
    offer_request(MODE_RAIN, 32'h7FFF_FFFF);           // huge manual level
    offer_request(MODE_SIDELOBE, 32'd0);
    offer_request(MODE_SIDELOBE, 32'h8000_0000);       // auto
    offer_request(4'd15, 32'hA5A5_5A5A);               // unknown kind
    offer_request(MODE_RANGE, 32'd1);
  endtask

  // Receiver stalls while the sender keeps offering long frames
  task automatic test_backpressure();
    calm = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) begin
      offer_request(MODE_GAIN + 4'($urandom_range(0, 2)), random_setting());
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  // Random kinds and values; the first stretch runs with no idling
  task automatic test_random();
    int         sent;
    logic [3:0] mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent < 40);
      mode = 4'($urandom_range(0, 15));
      offer_request(mode, random_setting());
      if (mode != 4'd15) sent++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("radar_control_command_encoder test passed");
    end else begin
      $display("radar_control_command_encoder test failed");
    end
    $finish;
  end

endmodule
